// File: rtl/linear_system_solver_core_defines.svh
// assertion macros for the linear system solver checker
// needs clk and rst_n in the scope where a macro is used
`ifndef LINEAR_SYSTEM_SOLVER_CORE_DEFINES_SVH
`define LINEAR_SYSTEM_SOLVER_CORE_DEFINES_SVH

// same-cycle implication
`define LSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lss_pkg.sv
// shared types and constants for the linear system solver
// no dependencies
package lss_pkg;

    localparam int SIZE_W = 7;
    localparam int VAL_W  = 64;
    localparam int IDX_W  = 6;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    localparam logic [VAL_W-1:0] SIGN64 = 64'h8000_0000_0000_0000;
    localparam logic [VAL_W-1:0] MAXPOS = 64'h7FFF_FFFF_FFFF_FFFF;

    // request to the shared arithmetic unit
    typedef struct packed {
        logic             start;
        logic             op_div;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
    } alu_req_t;

    // response from the shared arithmetic unit
    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] result;
    } alu_rsp_t;

endpackage

// File: rtl/lss_if.sv
// valid/ready channels for matrix entries and solution values
// depends on lss_pkg
interface lss_entry_if;
    logic                            valid;
    logic                            ready;
    logic signed [lss_pkg::VAL_W-1:0] entry_value;

    modport source (output valid, output entry_value, input ready);
    modport sink   (input valid, input entry_value, output ready);
endinterface

interface lss_solution_if;
    logic                             valid;
    logic                             ready;
    logic signed [lss_pkg::VAL_W-1:0] solution_value;
    logic [lss_pkg::IDX_W-1:0]        row_index;
    logic                             last_of_run;
    logic                             singular;

    modport source (output valid, output solution_value, output row_index,
                    output last_of_run, output singular, input ready);
    modport sink   (input valid, input solution_value, input row_index,
                    input last_of_run, input singular, output ready);
endinterface

// File: rtl/lss_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module lss_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4160
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/lss_alu.sv
// shared q31.32 multiply and divide unit, multi-cycle
// depends on lss_pkg
module lss_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  lss_pkg::alu_req_t req,
    output lss_pkg::alu_rsp_t rsp
);

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_MUL  = 3'd1;
    localparam logic [2:0] A_MFIN = 3'd2;
    localparam logic [2:0] A_DIV  = 3'd3;
    localparam logic [2:0] A_RND  = 3'd4;
    localparam logic [2:0] A_INC  = 3'd5;
    localparam logic [2:0] A_SGN  = 3'd6;

    localparam logic [6:0] MUL_LAST = 7'd4;
    localparam logic [6:0] DIV_LAST = 7'd95;

    logic [2:0]   st_reg;
    logic [6:0]   cnt_reg;
    logic         neg_reg;
    logic [63:0]  x_reg;
    logic [63:0]  y_reg;
    logic [127:0] acc_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   sh_reg;
    logic [95:0]  num_reg;
    logic [63:0]  rem_reg;
    logic [63:0]  q_reg;
    logic         rnd_reg;
    logic [63:0]  mag_reg;
    logic         over_reg;
    logic [63:0]  res_reg;
    logic         done_reg;

    logic [63:0]  a_mag;
    logic [63:0]  b_mag;
    logic [31:0]  x_half;
    logic [31:0]  y_half;
    logic [127:0] pp_shifted;
    logic [64:0]  rem_shift;
    logic         take;
    logic [63:0]  lim;

    // operand magnitudes
    assign a_mag = req.a[63] ? (64'd0 - req.a) : req.a;
    assign b_mag = req.b[63] ? (64'd0 - req.b) : req.b;

    // partial product operand halves
    assign x_half = cnt_reg[1] ? x_reg[63:32] : x_reg[31:0];
    assign y_half = cnt_reg[0] ? y_reg[63:32] : y_reg[31:0];

    // alignment of the previous partial product
    always_comb
    begin
        unique case (sh_reg)
            2'd0:    pp_shifted = {64'd0, pp_reg};
            2'd1:    pp_shifted = {32'd0, pp_reg, 32'd0};
            default: pp_shifted = {pp_reg, 64'd0};
        endcase
    end

    // restoring divide step
    assign rem_shift = {rem_reg, num_reg[95]};
    assign take      = rem_shift[64] || (rem_shift[63:0] >= y_reg);

    assign lim = neg_reg ? lss_pkg::SIGN64 : lss_pkg::MAXPOS;

    // sequencer and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= A_IDLE;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (st_reg)
                A_IDLE:
                begin
                    if (req.start)
                    begin
                        neg_reg  <= req.a[63] ^ req.b[63];
                        x_reg    <= a_mag;
                        y_reg    <= b_mag;
                        cnt_reg  <= '0;
                        acc_reg  <= 128'h8000_0000;
                        num_reg  <= {a_mag, 32'd0};
                        rem_reg  <= '0;
                        q_reg    <= '0;
                        over_reg <= 1'b0;
                        st_reg   <= req.op_div ? A_DIV : A_MUL;
                    end
                end
                A_MUL:
                begin
                    pp_reg  <= x_half * y_half;
                    sh_reg  <= 2'({1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]});
                    if (cnt_reg != '0)
                    begin
                        acc_reg <= acc_reg + pp_shifted;
                    end
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == MUL_LAST)
                    begin
                        st_reg <= A_MFIN;
                    end
                end
                A_MFIN:
                begin
                    mag_reg  <= acc_reg[95:32];
                    over_reg <= |acc_reg[127:96];
                    st_reg   <= A_SGN;
                end
                A_DIV:
                begin
                    num_reg <= {num_reg[94:0], 1'b0};
                    q_reg   <= {q_reg[62:0], take};
                    rem_reg <= take ? (rem_shift[63:0] - y_reg) : rem_shift[63:0];
                    if (take && (cnt_reg < 7'd32))
                    begin
                        over_reg <= 1'b1;
                    end
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == DIV_LAST)
                    begin
                        st_reg <= A_RND;
                    end
                end
                A_RND:
                begin
                    rnd_reg <= rem_reg >= (y_reg - rem_reg);
                    st_reg  <= A_INC;
                end
                A_INC:
                begin
                    mag_reg <= q_reg;
                    if (rnd_reg)
                    begin
                        if (&q_reg)
                        begin
                            over_reg <= 1'b1;
                        end
                        else
                        begin
                            mag_reg <= q_reg + 64'd1;
                        end
                    end
                    st_reg <= A_SGN;
                end
                A_SGN:
                begin
                    if (over_reg || (mag_reg > lim))
                    begin
                        res_reg <= neg_reg ? (64'd0 - lim) : lim;
                    end
                    else
                    begin
                        res_reg <= neg_reg ? (64'd0 - mag_reg) : mag_reg;
                    end
                    done_reg <= 1'b1;
                    st_reg   <= A_IDLE;
                end
                default:
                begin
                    st_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

// File: rtl/linear_system_solver_core.sv
// linear system solver top level: loader, elimination sequencer, result port
// depends on lss_pkg, lss_if, lss_ram, lss_alu
//
//  channel      dir  payload                                          beat
//  entry_ch     in   entry_value (q31.32)                             one matrix entry
//  solution_ch  out  solution_value, row_index, last_of_run, singular one unknown
//  cfg          in   cfg_wdata (size)                                 cfg_we high
//
// loading accepts one entry per cycle; after the last entry the block is busy
// for the whole solve, about n^3/3 multiply steps and n^2/2 divides, all
// through one shared multiply/divide unit and one matrix ram. results leave
// one at a time, each held until the output channel takes it.
// reset clears control only; the matrix ram holds no reset value.
module linear_system_solver_core #(
    parameter int MAX_SIZE = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    lss_entry_if.sink                    entry_ch,
    lss_solution_if.source               solution_ch,
    input  logic                         cfg_we,
    input  logic [lss_pkg::SIZE_W-1:0]   cfg_wdata
);

    localparam int DEPTH = MAX_SIZE * (MAX_SIZE + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_SIZE + 2);
    localparam int LW    = 2 * CW;

    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_PIV_INIT  = 5'd1;
    localparam logic [4:0] ST_PIV_FIRST = 5'd2;
    localparam logic [4:0] ST_PIV_CMP   = 5'd3;
    localparam logic [4:0] ST_SWAP_CHK  = 5'd4;
    localparam logic [4:0] ST_SWAP_A    = 5'd5;
    localparam logic [4:0] ST_SWAP_B    = 5'd6;
    localparam logic [4:0] ST_SWAP_C    = 5'd7;
    localparam logic [4:0] ST_SWAP_D    = 5'd8;
    localparam logic [4:0] ST_PIV_RD    = 5'd9;
    localparam logic [4:0] ST_PIV_CHK   = 5'd10;
    localparam logic [4:0] ST_DIV_RD    = 5'd11;
    localparam logic [4:0] ST_DIV_GO    = 5'd12;
    localparam logic [4:0] ST_DIV_WAIT  = 5'd13;
    localparam logic [4:0] ST_EF_RD     = 5'd14;
    localparam logic [4:0] ST_EF        = 5'd15;
    localparam logic [4:0] ST_E_RD1     = 5'd16;
    localparam logic [4:0] ST_E_RD2     = 5'd17;
    localparam logic [4:0] ST_E_MUL     = 5'd18;
    localparam logic [4:0] ST_E_WAIT    = 5'd19;
    localparam logic [4:0] ST_COL_NEXT  = 5'd20;
    localparam logic [4:0] ST_B_ROW     = 5'd21;
    localparam logic [4:0] ST_B_RD1     = 5'd22;
    localparam logic [4:0] ST_B_RD2     = 5'd23;
    localparam logic [4:0] ST_B_RD3     = 5'd24;
    localparam logic [4:0] ST_B_MUL     = 5'd25;
    localparam logic [4:0] ST_B_WAIT    = 5'd26;
    localparam logic [4:0] ST_O_RD      = 5'd27;
    localparam logic [4:0] ST_O_LOAD    = 5'd28;
    localparam logic [4:0] ST_O_HOLD    = 5'd29;

    logic [4:0]                  st_reg;
    logic [lss_pkg::SIZE_W-1:0]  size_reg;
    logic [AW-1:0]               load_pos_reg;
    logic [CW-1:0]               i_reg;
    logic [CW-1:0]               j_reg;
    logic [CW-1:0]               k_reg;
    logic [CW-1:0]               t_reg;
    logic [63:0]                 best_reg;
    logic [63:0]                 a_reg;
    logic [63:0]                 b_reg;
    logic [63:0]                 f_reg;
    logic [63:0]                 piv_reg;
    logic                        sing_reg;
    logic                        out_valid_reg;
    logic [63:0]                 out_value_reg;
    logic [lss_pkg::IDX_W-1:0]   out_idx_reg;
    logic                        out_last_reg;

    logic [CW-1:0]               n;
    logic [CW-1:0]               w;
    logic [LW-1:0]               total;
    logic [CW-1:0]               rd_row;
    logic [CW-1:0]               rd_col;
    logic [CW-1:0]               wr_row;
    logic [CW-1:0]               wr_col;
    logic [LW-1:0]               rd_lin;
    logic [LW-1:0]               wr_lin;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [AW-1:0]               ram_raddr;
    logic [63:0]                 ram_wdata;
    logic [63:0]                 ram_rdata;
    logic [63:0]                 rd_mag;
    logic [AW-1:0]               load_addr;
    logic                        in_beat;
    logic                        out_beat;
    lss_pkg::alu_req_t           alu_req;
    lss_pkg::alu_rsp_t           alu_rsp;

    // saturating q31.32 subtract
    function automatic logic [63:0] q_sub(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] d;
        d = x - y;
        if ((x[63] ^ y[63]) && (d[63] ^ x[63]))
        begin
            return x[63] ? lss_pkg::SIGN64 : lss_pkg::MAXPOS;
        end
        return d;
    endfunction

    // effective size, clamped to 1..MAX_SIZE
    always_comb
    begin
        priority if (size_reg == '0)
        begin
            n = CW'(1);
        end
        else if (int'(size_reg) > MAX_SIZE)
        begin
            n = CW'(MAX_SIZE);
        end
        else
        begin
            n = CW'(size_reg);
        end
    end

    assign w     = n + CW'(1);
    assign total = LW'(n) * LW'(w);

    assign in_beat  = entry_ch.valid && entry_ch.ready;
    assign out_beat = out_valid_reg && solution_ch.ready;
    assign rd_mag   = ram_rdata[63] ? (64'd0 - ram_rdata) : ram_rdata;
    assign load_addr = (LW'(load_pos_reg) >= total) ? '0 : load_pos_reg;

    // ram address selection per sequencer step
    always_comb
    begin
        rd_row    = i_reg;
        rd_col    = i_reg;
        wr_row    = i_reg;
        wr_col    = k_reg;
        ram_we    = 1'b0;
        ram_wdata = alu_rsp.result;
        unique case (st_reg)
            ST_PIV_FIRST:
            begin
                rd_row = i_reg + CW'(1);
            end
            ST_PIV_CMP:
            begin
                rd_row = j_reg + CW'(1);
            end
            ST_SWAP_A:
            begin
                rd_col = k_reg;
            end
            ST_SWAP_B:
            begin
                rd_row = t_reg;
                rd_col = k_reg;
            end
            ST_SWAP_C:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            ST_SWAP_D:
            begin
                ram_we    = 1'b1;
                wr_row    = t_reg;
                ram_wdata = a_reg;
            end
            ST_DIV_RD:
            begin
                rd_col = k_reg;
            end
            ST_DIV_WAIT:
            begin
                ram_we = alu_rsp.done;
            end
            ST_EF_RD:
            begin
                rd_row = j_reg;
            end
            ST_E_RD1:
            begin
                rd_col = k_reg;
            end
            ST_E_RD2:
            begin
                rd_row = j_reg;
                rd_col = k_reg;
            end
            ST_E_WAIT:
            begin
                ram_we    = alu_rsp.done;
                wr_row    = j_reg;
                ram_wdata = q_sub(b_reg, alu_rsp.result);
            end
            ST_B_RD1:
            begin
                rd_col = n;
            end
            ST_B_RD2:
            begin
                rd_row = j_reg;
                rd_col = n;
            end
            ST_B_RD3:
            begin
                rd_col = j_reg;
            end
            ST_B_WAIT:
            begin
                ram_we    = alu_rsp.done;
                wr_col    = n;
                ram_wdata = q_sub(a_reg, alu_rsp.result);
            end
            ST_O_RD:
            begin
                rd_col = n;
            end
            ST_IDLE:
            begin
                ram_we    = in_beat;
                ram_wdata = entry_ch.entry_value;
            end
            default:
            begin
                rd_row = i_reg;
            end
        endcase
    end

    // linear addresses, row-major with row length n+1
    assign rd_lin    = LW'(rd_row) * LW'(w) + LW'(rd_col);
    assign wr_lin    = LW'(wr_row) * LW'(w) + LW'(wr_col);
    assign ram_raddr = AW'(rd_lin);
    assign ram_waddr = (st_reg == ST_IDLE) ? load_addr : AW'(wr_lin);

    // requests to the shared arithmetic unit
    always_comb
    begin
        alu_req.start  = 1'b0;
        alu_req.op_div = 1'b0;
        alu_req.a      = a_reg;
        alu_req.b      = f_reg;
        unique case (st_reg)
            ST_DIV_GO:
            begin
                alu_req.start  = 1'b1;
                alu_req.op_div = 1'b1;
                alu_req.a      = ram_rdata;
                alu_req.b      = piv_reg;
            end
            ST_E_MUL:
            begin
                alu_req.start = 1'b1;
            end
            ST_B_MUL:
            begin
                alu_req.start = 1'b1;
                alu_req.a     = b_reg;
                alu_req.b     = ram_rdata;
            end
            default:
            begin
                alu_req.start = 1'b0;
            end
        endcase
    end

    // matrix storage
    lss_ram #(
        .WIDTH (lss_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared multiply and divide
    lss_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            size_reg      <= lss_pkg::SIZE_RESET;
            load_pos_reg  <= '0;
            sing_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            t_reg         <= '0;
        end
        else
        begin
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (in_beat)
                    begin
                        if (LW'(load_addr) + LW'(1) >= total)
                        begin
                            load_pos_reg <= '0;
                            sing_reg     <= 1'b0;
                            i_reg        <= '0;
                            st_reg       <= ST_PIV_INIT;
                        end
                        else
                        begin
                            load_pos_reg <= load_addr + AW'(1);
                        end
                    end
                end
                // pivot search down column i
                ST_PIV_INIT:
                begin
                    t_reg  <= i_reg;
                    st_reg <= ST_PIV_FIRST;
                end
                ST_PIV_FIRST:
                begin
                    best_reg <= rd_mag;
                    j_reg    <= i_reg + CW'(1);
                    st_reg   <= (i_reg + CW'(1) < n) ? ST_PIV_CMP : ST_SWAP_CHK;
                end
                ST_PIV_CMP:
                begin
                    if (rd_mag > best_reg)
                    begin
                        best_reg <= rd_mag;
                        t_reg    <= j_reg;
                    end
                    j_reg  <= j_reg + CW'(1);
                    st_reg <= (j_reg + CW'(1) < n) ? ST_PIV_CMP : ST_SWAP_CHK;
                end
                // row exchange, one column a pass
                ST_SWAP_CHK:
                begin
                    k_reg  <= '0;
                    st_reg <= (t_reg != i_reg) ? ST_SWAP_A : ST_PIV_RD;
                end
                ST_SWAP_A:
                begin
                    st_reg <= ST_SWAP_B;
                end
                ST_SWAP_B:
                begin
                    a_reg  <= ram_rdata;
                    st_reg <= ST_SWAP_C;
                end
                ST_SWAP_C:
                begin
                    st_reg <= ST_SWAP_D;
                end
                ST_SWAP_D:
                begin
                    k_reg  <= k_reg + CW'(1);
                    st_reg <= (k_reg + CW'(1) < w) ? ST_SWAP_A : ST_PIV_RD;
                end
                ST_PIV_RD:
                begin
                    st_reg <= ST_PIV_CHK;
                end
                ST_PIV_CHK:
                begin
                    piv_reg <= ram_rdata;
                    k_reg   <= i_reg;
                    if (ram_rdata == '0)
                    begin
                        sing_reg <= 1'b1;
                        i_reg    <= '0;
                        st_reg   <= ST_O_RD;
                    end
                    else
                    begin
                        st_reg <= ST_DIV_RD;
                    end
                end
                // pivot row normalisation
                ST_DIV_RD:
                begin
                    st_reg <= ST_DIV_GO;
                end
                ST_DIV_GO:
                begin
                    st_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (alu_rsp.done)
                    begin
                        k_reg <= k_reg + CW'(1);
                        j_reg <= i_reg + CW'(1);
                        priority if (k_reg + CW'(1) < w)
                        begin
                            st_reg <= ST_DIV_RD;
                        end
                        else if (i_reg + CW'(1) < n)
                        begin
                            st_reg <= ST_EF_RD;
                        end
                        else
                        begin
                            st_reg <= ST_COL_NEXT;
                        end
                    end
                end
                // elimination of the rows below
                ST_EF_RD:
                begin
                    st_reg <= ST_EF;
                end
                ST_EF:
                begin
                    f_reg  <= ram_rdata;
                    k_reg  <= i_reg;
                    st_reg <= ST_E_RD1;
                end
                ST_E_RD1:
                begin
                    st_reg <= ST_E_RD2;
                end
                ST_E_RD2:
                begin
                    a_reg  <= ram_rdata;
                    st_reg <= ST_E_MUL;
                end
                ST_E_MUL:
                begin
                    b_reg  <= ram_rdata;
                    st_reg <= ST_E_WAIT;
                end
                ST_E_WAIT:
                begin
                    if (alu_rsp.done)
                    begin
                        priority if (k_reg + CW'(1) < w)
                        begin
                            k_reg  <= k_reg + CW'(1);
                            st_reg <= ST_E_RD1;
                        end
                        else if (j_reg + CW'(1) < n)
                        begin
                            j_reg  <= j_reg + CW'(1);
                            st_reg <= ST_EF_RD;
                        end
                        else
                        begin
                            st_reg <= ST_COL_NEXT;
                        end
                    end
                end
                ST_COL_NEXT:
                begin
                    if (i_reg + CW'(1) < n)
                    begin
                        i_reg  <= i_reg + CW'(1);
                        st_reg <= ST_PIV_INIT;
                    end
                    else
                    begin
                        st_reg <= ST_B_ROW;
                    end
                end
                // back substitution, last row upwards
                ST_B_ROW:
                begin
                    j_reg <= i_reg + CW'(1);
                    priority if (i_reg + CW'(1) < n)
                    begin
                        st_reg <= ST_B_RD1;
                    end
                    else if (i_reg == '0)
                    begin
                        st_reg <= ST_O_RD;
                    end
                    else
                    begin
                        i_reg <= i_reg - CW'(1);
                    end
                end
                ST_B_RD1:
                begin
                    st_reg <= ST_B_RD2;
                end
                ST_B_RD2:
                begin
                    a_reg  <= ram_rdata;
                    st_reg <= ST_B_RD3;
                end
                ST_B_RD3:
                begin
                    b_reg  <= ram_rdata;
                    st_reg <= ST_B_MUL;
                end
                ST_B_MUL:
                begin
                    st_reg <= ST_B_WAIT;
                end
                ST_B_WAIT:
                begin
                    if (alu_rsp.done)
                    begin
                        priority if (j_reg + CW'(1) < n)
                        begin
                            j_reg  <= j_reg + CW'(1);
                            st_reg <= ST_B_RD1;
                        end
                        else if (i_reg == '0)
                        begin
                            st_reg <= ST_O_RD;
                        end
                        else
                        begin
                            i_reg  <= i_reg - CW'(1);
                            st_reg <= ST_B_ROW;
                        end
                    end
                end
                // result beats
                ST_O_RD:
                begin
                    st_reg <= ST_O_LOAD;
                end
                ST_O_LOAD:
                begin
                    out_valid_reg <= 1'b1;
                    out_value_reg <= sing_reg ? '0 : ram_rdata;
                    out_idx_reg   <= lss_pkg::IDX_W'(i_reg);
                    out_last_reg  <= (i_reg + CW'(1) == n);
                    st_reg        <= ST_O_HOLD;
                end
                ST_O_HOLD:
                begin
                    if (out_beat)
                    begin
                        out_valid_reg <= 1'b0;
                        i_reg         <= i_reg + CW'(1);
                        st_reg        <= (i_reg + CW'(1) < n) ? ST_O_RD : ST_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= ST_IDLE;
                end
            endcase

            // size register write restarts loading
            if (cfg_we)
            begin
                size_reg     <= cfg_wdata;
                load_pos_reg <= '0;
            end
        end
    end

    assign entry_ch.ready             = (st_reg == ST_IDLE);
    assign solution_ch.valid          = out_valid_reg;
    assign solution_ch.solution_value = out_value_reg;
    assign solution_ch.row_index      = out_idx_reg;
    assign solution_ch.last_of_run    = out_last_reg;
    assign solution_ch.singular       = sing_reg;

endmodule

// File: rtl/lss_checker.sv
// port-level checker for the linear system solver, bound to the top level
// depends on lss_pkg and linear_system_solver_core_defines.svh
`include "linear_system_solver_core_defines.svh"

module lss_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [lss_pkg::VAL_W-1:0]  solution_value,
    input logic                       last_of_run,
    input logic                       singular
);

    // stalled result beat holds
    `LSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(solution_value), "result beat changed while stalled")

    // no entry is taken while results are pending
    `LSS_ASSERT_NOW(a_no_overlap, out_valid, !in_ready, "entry accepted during result phase")

    // an entry beat only lands while the result side is quiet
    `LSS_ASSERT_NOW(a_in_quiet, in_valid && in_ready, !out_valid,
        "entry beat while a result is offered")

    // singular results carry zero
    `LSS_ASSERT_NOW(a_sing_zero, out_valid && singular, solution_value == '0,
        "singular result not zero")

    // run ends after the last beat
    `LSS_ASSERT_NEXT(a_last_end, out_valid && out_ready && last_of_run, !out_valid,
        "result beat after last of run")

endmodule

bind linear_system_solver_core lss_checker u_lss_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (entry_ch.valid),
    .in_ready       (entry_ch.ready),
    .out_valid      (solution_ch.valid),
    .out_ready      (solution_ch.ready),
    .solution_value (solution_ch.solution_value),
    .last_of_run    (solution_ch.last_of_run),
    .singular       (solution_ch.singular)
);
